// File: rtl/fcm_pkg.sv
// ----------------------------------------------------------------------------
// fcm_pkg
// Shared types and constants for the fixed-capacity multiset.
// ----------------------------------------------------------------------------
package fcm_pkg;

  // Default configuration
  localparam int CAPACITY_DEF   = 16;
  localparam int ITEM_WIDTH_DEF = 32;

  // Port field widths
  localparam int ENTRY_W     = 32;
  localparam int FUNC_W      = 2;
  localparam int FIELD_W     = 5;   // frequency and size fields
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // Result field positions in the output tdata
  localparam int OUT_OK_B    = 0;
  localparam int OUT_FOUND_B = 1;
  localparam int OUT_FREQ_LO = 2;
  localparam int OUT_SIZE_LO = 7;
  localparam int OUT_EMPTY_B = 12;

  // Request operation codes
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

endpackage

// File: rtl/fcm_cell.sv
// ----------------------------------------------------------------------------
// fcm_cell
// One slot of the bag: holds a stored word, compares it against the request
// token passing through and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fcm_cell #(
  parameter int ITEM_WIDTH = fcm_pkg::ITEM_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX_W      = 4,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CNT_W-1:0]      cnt,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_idx,
  input  logic [ITEM_WIDTH-1:0] wr_data,
  input  logic                  in_valid,
  input  logic [ITEM_WIDTH-1:0] in_val,
  input  logic [CNT_W-1:0]      in_freq,
  input  logic                  in_hit,
  input  logic [IDX_W-1:0]      in_first,
  input  logic [ITEM_WIDTH-1:0] in_last,
  output logic                  out_valid,
  output logic [ITEM_WIDTH-1:0] out_val,
  output logic [CNT_W-1:0]      out_freq,
  output logic                  out_hit,
  output logic [IDX_W-1:0]      out_first,
  output logic [ITEM_WIDTH-1:0] out_last
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);
  localparam logic [IDX_W-1:0] IDX_I  = IDX_W'(IDX);

  logic [ITEM_WIDTH-1:0] slot;
  logic                  match;

  // Only slots below the fill count take part
  assign match = (cnt > IDX_C) && (slot == in_val);

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_I)) begin
      slot <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_val   <= in_val;
      out_freq  <= in_freq + CNT_W'(match);
      out_hit   <= in_hit | match;
      out_first <= (match && !in_hit) ? IDX_I : in_first;
      // pick up the last stored word on the way past
      out_last  <= (cnt == NEXT_C) ? slot : in_last;
    end
  end

endmodule

// File: rtl/fixed_capacity_multiset.sv
// ----------------------------------------------------------------------------
// fixed_capacity_multiset
// Bag of up to CAPACITY words built as a row of slot cells. A request token
// walks the row, counting copies of the entry, noting the first match and
// the last stored word; the controller then applies add, remove or clear.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                   payload
//  --------  ---  ------------------------  --------------------------------
//  request   in   s_tvalid/s_tready         s_tdata: entry; s_tuser: func
//  result    out  m_tvalid/m_tready         m_tdata: ok, found, frequency,
//                                           size, empty_res
//
//  A result is loaded once its request has walked the row: the token crosses
//  one cell per cycle (the accepting edge loads the first), the tail is seen
//  in S_SWEEP, which then moves to S_FIN, and the update commits from S_FIN.
//  One request is in flight at a time; s_tready is high only while idle, so
//  a new request is taken only after the previous one has committed.
//  A result waiting on m_tready does not block the next request, but the
//  commit of that next request holds until the output register is free.
//  Reset (rst, synchronous) empties the bag; slot contents are not cleared.
//
module fixed_capacity_multiset #(
  parameter int CAPACITY   = fcm_pkg::CAPACITY_DEF,
  parameter int ITEM_WIDTH = fcm_pkg::ITEM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [fcm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [31:0] entry
  input  logic [fcm_pkg::FUNC_W-1:0]       s_tuser,   // [1:0] func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] ok, [1] found, [6:2] frequency, [11:7] size, [12] empty_res, [15:13] 0
  output logic [fcm_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_FIN   = 3'b100
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]      count;
  fcm_pkg::op_t          op;
  logic                  accept;
  logic [63:0]           entry_ext;

  // Token chain: position k feeds cell k, position CAPACITY is the tail
  logic                  tok_valid [0:CAPACITY];
  logic [ITEM_WIDTH-1:0] tok_val   [0:CAPACITY];
  logic [CNT_W-1:0]      tok_freq  [0:CAPACITY];
  logic                  tok_hit   [0:CAPACITY];
  logic [IDX_W-1:0]      tok_first [0:CAPACITY];
  logic [ITEM_WIDTH-1:0] tok_last  [0:CAPACITY];

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  logic [ITEM_WIDTH-1:0] wr_data;

  logic                  commit;
  logic                  res_ok;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W+4:0]      freq_ext;
  logic [CNT_W+4:0]      size_ext;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign entry_ext = {32'b0, s_tdata};

  // Inject a fresh token at the head of the row
  assign tok_valid[0] = accept;
  assign tok_val[0]   = entry_ext[ITEM_WIDTH-1:0];
  assign tok_freq[0]  = '0;
  assign tok_hit[0]   = 1'b0;
  assign tok_first[0] = '0;
  assign tok_last[0]  = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    fcm_cell #(
      .ITEM_WIDTH (ITEM_WIDTH),
      .CNT_W      (CNT_W),
      .IDX_W      (IDX_W),
      .IDX        (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cnt       (count),
      .wr_en     (wr_en),
      .wr_idx    (wr_idx),
      .wr_data   (wr_data),
      .in_valid  (tok_valid[k]),
      .in_val    (tok_val[k]),
      .in_freq   (tok_freq[k]),
      .in_hit    (tok_hit[k]),
      .in_first  (tok_first[k]),
      .in_last   (tok_last[k]),
      .out_valid (tok_valid[k+1]),
      .out_val   (tok_val[k+1]),
      .out_freq  (tok_freq[k+1]),
      .out_hit   (tok_hit[k+1]),
      .out_first (tok_first[k+1]),
      .out_last  (tok_last[k+1])
    );
  end

  // Hold the operation for the commit step
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= fcm_pkg::op_t'(s_tuser);
    end
  end

  // Commit once the tail token has settled and the output register is free
  assign commit = (state == S_FIN) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SWEEP;
      S_SWEEP: if (tok_valid[CAPACITY]) state_next = S_FIN;
      S_FIN:   if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Work out the update from the tail token
  always_comb begin
    res_ok     = 1'b1;
    count_next = count;
    wr_en      = 1'b0;
    wr_idx     = count[IDX_W-1:0];
    wr_data    = tok_val[CAPACITY];
    case (op)
      fcm_pkg::OP_ADD: begin
        if (count < CAP_C) begin
          count_next = count + ONE_C;
          wr_en      = commit;
        end else begin
          res_ok = 1'b0;
        end
      end
      fcm_pkg::OP_REMOVE: begin
        // move the last stored word into the first matching slot
        if (tok_hit[CAPACITY]) begin
          count_next = count - ONE_C;
          wr_en      = commit;
          wr_idx     = tok_first[CAPACITY];
          wr_data    = tok_last[CAPACITY];
        end else begin
          res_ok = 1'b0;
        end
      end
      fcm_pkg::OP_CLEAR: count_next = '0;
      fcm_pkg::OP_QUERY: count_next = count;
      default:           count_next = count;
    endcase
  end

  assign freq_ext = {5'b0, tok_freq[CAPACITY]};
  assign size_ext = {5'b0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {3'b0,
                  (count_next == '0),
                  size_ext[fcm_pkg::FIELD_W-1:0],
                  freq_ext[fcm_pkg::FIELD_W-1:0],
                  tok_hit[CAPACITY],
                  res_ok};
    end
  end

endmodule

// File: rtl/fcm_checker.sv
// ----------------------------------------------------------------------------
// fcm_checker
// Port-level checks for the fixed-capacity multiset, bound to the top level.
// ----------------------------------------------------------------------------
module fcm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fcm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // One request at a time: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in flight");

  // An absent entry has no copies
  a_found_freq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[fcm_pkg::OUT_FOUND_B]) |->
      (m_tdata[fcm_pkg::OUT_FREQ_LO +: fcm_pkg::FIELD_W] == '0))
    else $error("frequency nonzero for absent entry");

  // A result needs a request: none may follow reset directly
  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind fixed_capacity_multiset fcm_checker u_fcm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/tb_fixed_capacity_multiset.sv
// ----------------------------------------------------------------------------
// tb_fixed_capacity_multiset
// Self-checking bench for the fixed-capacity multiset. A shadow bag tracks
// every accepted request and predicts ok, found, frequency, size and the
// empty flag, which are compared field by field against each result. A
// short directed sequence covers the corner cases, and random bursts of
// fill, drain and mixed traffic follow. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_capacity_multiset;
  import fcm_pkg::*;

  localparam int CAP            = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1825;
  localparam int HOLD_OFF_LEN   = 300;      // long receiver hold-off, in cycles
  localparam int HOLD_OFF_AFTER = 400;      // results seen before the hold-off
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int MAX_PRINTS     = 20;

  // Expected content of one result
  typedef struct packed {
    logic             ok;
    logic             found;
    logic [FIELD_W-1:0] frequency;
    logic [FIELD_W-1:0] size;
    logic             empty_res;
  } bag_result_t;

  // Traffic mix of one random burst
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_NOISE} burst_mix_t;

  // Shadow copy of the bag plus the queue of results still owed by the block
  class bag_mirror;
    logic [ENTRY_W-1:0] slots[CAP];
    int                 count;
    bag_result_t        owed[$];
    int                 errors;
    int                 results_seen;
    int                 op_seen[4];
    int                 full_rejects;
    int                 remove_misses;
    int                 peak_freq;

    function new();
      count = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    // Update the shadow bag for one accepted request and queue its result
    function void apply_request(op_t op, logic [ENTRY_W-1:0] entry);
      bag_result_t res;
      int freq, first;
      freq  = 0;
      first = -1;
      for (int i = 0; i < count; i++) begin
        if (slots[i] == entry) begin
          if (first < 0) first = i;
          freq++;
        end
      end
      res.ok = 1'b1;
      case (op)
        OP_ADD: begin
          if (count < CAP) begin
            slots[count] = entry;
            count++;
          end else begin
            res.ok = 1'b0;
            full_rejects++;
          end
        end
        OP_REMOVE: begin
          // backfill the hole with the last stored word
          if (first >= 0) begin
            count--;
            slots[first] = slots[count];
          end else begin
            res.ok = 1'b0;
            remove_misses++;
          end
        end
        OP_CLEAR: count = 0;
        default: ;
      endcase
      res.found     = (first >= 0);
      res.frequency = freq[FIELD_W-1:0];
      res.size      = count[FIELD_W-1:0];
      res.empty_res = (count == 0);
      if (freq > peak_freq) peak_freq = freq;
      op_seen[op]++;
      owed.insert(owed.size(), res);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t mismatch on result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    task check_result(logic [OUT_TDATA_W-1:0] word);
      bag_result_t want;
      results_seen++;
      if (owed.size() == 0) begin
        report_mismatch("result with nothing owed, tdata", word, 0);
        return;
      end
      want = owed.pop_front();
      if (word[OUT_OK_B] !== want.ok)
        report_mismatch("ok", word[OUT_OK_B], want.ok);
      if (word[OUT_FOUND_B] !== want.found)
        report_mismatch("found", word[OUT_FOUND_B], want.found);
      if (word[OUT_FREQ_LO +: FIELD_W] !== want.frequency)
        report_mismatch("frequency", word[OUT_FREQ_LO +: FIELD_W], want.frequency);
      if (word[OUT_SIZE_LO +: FIELD_W] !== want.size)
        report_mismatch("size", word[OUT_SIZE_LO +: FIELD_W], want.size);
      if (word[OUT_EMPTY_B] !== want.empty_res)
        report_mismatch("empty_res", word[OUT_EMPTY_B], want.empty_res);
      if (word[OUT_TDATA_W-1:OUT_EMPTY_B+1] !== '0)
        report_mismatch("pad bits", word[OUT_TDATA_W-1:OUT_EMPTY_B+1], 0);
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;    // [31:0] entry
  logic [FUNC_W-1:0]      s_tuser;    // [1:0] func
  logic                   m_tvalid;
  logic                   m_tready;
  // [0] ok, [1] found, [6:2] frequency, [11:7] size, [12] empty_res, [15:13] 0
  logic [OUT_TDATA_W-1:0] m_tdata;

  bag_mirror bag;
  bit        quiet;          // no random idle gaps picked on either side while set
  bit        hold_off_done;
  int        cycles;

  fixed_capacity_multiset #(
    .CAPACITY   (CAP),
    .ITEM_WIDTH (ITEM_WIDTH_DEF)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, bag.owed.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_off_done && bag.results_seen >= HOLD_OFF_AFTER) begin
        hold_off_done = 1'b1;
        m_tready = 1'b0;
        repeat (HOLD_OFF_LEN - 1) @(negedge clk);
        stall_left = 0;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Score every result at the edge that accepts it
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) bag.check_result(m_tdata);
  end

  // Offer one request, hold it until accepted, then idle for a random gap
  task automatic send_request(op_t op, logic [ENTRY_W-1:0] entry);
    int gap;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = entry;
    do @(posedge clk); while (!s_tready);
    bag.apply_request(op, entry);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = $urandom;
      s_tuser  = op_t'($urandom_range(0, 3));
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic run_directed();
    send_request(OP_QUERY,  32'h0000_0000);   // query on an empty bag
    send_request(OP_REMOVE, 32'h0000_0005);   // remove from an empty bag
    send_request(OP_ADD,    32'h0000_0000);
    send_request(OP_ADD,    32'hFFFF_FFFF);
    send_request(OP_ADD,    32'h0000_0000);   // duplicate: frequency 1 before
    send_request(OP_REMOVE, 32'h0000_0000);   // last word backfills slot 0
    send_request(OP_REMOVE, 32'h0000_1234);   // absent entry
    send_request(OP_CLEAR,  32'hFFFF_FFFF);
    // fill with one value, then add on a full bag
    repeat (CAP) send_request(OP_ADD, 32'h8000_0001);
    send_request(OP_ADD,    32'h8000_0001);
    send_request(OP_REMOVE, 32'h8000_0001);
    send_request(OP_CLEAR,  32'h0000_0000);
  endtask

  // Bursts with a small value pool so removes and queries hit stored words
  task automatic run_random(int n_items);
    logic [ENTRY_W-1:0] pool[6];
    logic [ENTRY_W-1:0] entry;
    burst_mix_t         mix;
    op_t                op;
    int                 sent, burst, span, r;
    sent = 0;
    foreach (pool[i]) pool[i] = $urandom;
    while (sent < n_items) begin
      burst = $urandom_range(20, 60);
      mix   = burst_mix_t'($urandom_range(0, 3));
      span  = $urandom_range(0, 5);
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) pool[$urandom_range(0, 5)] = $urandom;
      if ($urandom_range(0, 7) == 0) pool[0] = $urandom_range(0, 1) ? '1 : '0;
      repeat (burst) begin
        r = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:     op = (r < 75) ? OP_ADD : (r < 88) ? OP_QUERY :
                             (r < 99) ? OP_REMOVE : OP_CLEAR;
          MIX_DRAIN:    op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_ADD :
                             (r < 99) ? OP_QUERY : OP_CLEAR;
          MIX_BALANCED: op = (r < 40) ? OP_ADD : (r < 80) ? OP_REMOVE :
                             (r < 99) ? OP_QUERY : OP_CLEAR;
          default:      op = op_t'($urandom_range(0, 3));
        endcase
        if (mix != MIX_NOISE && $urandom_range(0, 99) < 85)
          entry = pool[$urandom_range(0, span)];
        else
          entry = $urandom;
        send_request(op, entry);
        sent++;
      end
    end
  endtask

  initial begin
    bag           = new();
    cycles        = 0;
    quiet         = 1'b0;
    hold_off_done = 1'b0;
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = OP_QUERY;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    run_random(RANDOM_ITEMS);
    @(negedge clk);
    s_tvalid = 1'b0;
    quiet    = 1'b1;

    // drain, then let the row settle in case a stray result follows
    while (bag.owed.size() > 0) @(posedge clk);
    repeat (CAP + 4) @(posedge clk);

    if (bag.owed.size() > 0)
      bag.report_mismatch("results never delivered", 0, bag.owed.size());
    $display("covered %0d results: %0d add, %0d remove, %0d clear, %0d query",
             bag.results_seen, bag.op_seen[OP_ADD], bag.op_seen[OP_REMOVE],
             bag.op_seen[OP_CLEAR], bag.op_seen[OP_QUERY]);
    $display("full-bag adds %0d, missed removes %0d, peak frequency %0d, %0d mismatches",
             bag.full_rejects, bag.remove_misses, bag.peak_freq, bag.errors);
    if (bag.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
